>>> hw/rtl/pr2d_pkg.sv
// Shared types and constants for the 2-D point rotation pipeline.
// Holds the fixed-point widths, gain constant and arctangent table.
// No dependencies.
package pr2d_pkg;

    // Fixed-point format of the rotation datapath
    localparam int FRAC_BITS = 30;
    localparam int W_COORD   = 16;
    localparam int W_PRE     = W_COORD + 1;
    localparam int W_RES     = 17;
    localparam int W_ACC     = 48;
    localparam int W_ANG     = 16;
    localparam int W_Z       = 32;
    localparam int TABLE_LEN = 24;

    // CORDIC gain compensation, 1/1.6468 scaled by 2^30
    localparam logic signed [30:0] GAIN_COMP = 31'sd652032874;

    // Quarter-turn codes
    localparam logic [1:0] QUAD_0   = 2'd0;
    localparam logic [1:0] QUAD_90  = 2'd1;
    localparam logic [1:0] QUAD_180 = 2'd2;
    localparam logic [1:0] QUAD_270 = 2'd3;

    // atan(2^-i), full circle = 2^32
    localparam logic signed [W_Z-1:0] ATAN_TAB [TABLE_LEN] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

    // One point in flight through the rotator
    typedef struct packed {
        logic signed [W_ACC-1:0] x;
        logic signed [W_ACC-1:0] y;
        logic signed [W_Z-1:0]   z;
        logic                    last;
    } t_rot;

endpackage

>>> hw/rtl/pr2d_in_if.sv
// Input channel: one point, its angle and the polygon end flag per beat.
// No dependencies.
interface pr2d_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] x_in;
    logic signed [15:0] y_in;
    logic        [15:0] angle;
    logic               last_in;

    modport source (output valid, x_in, y_in, angle, last_in, input ready);
    modport sink   (input valid, x_in, y_in, angle, last_in, output ready);
endinterface

>>> hw/rtl/pr2d_out_if.sv
// Output channel: one rotated point and its polygon end flag per beat.
// No dependencies.
interface pr2d_out_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] x_out;
    logic signed [16:0] y_out;
    logic               last_out;

    modport source (output valid, x_out, y_out, last_out, input ready);
    modport sink   (input valid, x_out, y_out, last_out, output ready);
endinterface

>>> hw/rtl/pr2d_prescale.sv
// Front stage: quarter-turn split, exact quadrant rotation and gain scaling.
// Depends on pr2d_pkg and pr2d_in_if.
module pr2d_prescale
    import pr2d_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    pr2d_in_if.sink        i_pt,
    output logic           o_valid,
    input  logic           i_ready,
    output t_rot           o_data
);

    logic                      r_valid;
    t_rot                      r_data;
    t_rot                      n_data;
    logic [W_ANG-1:0]          w_ang_bias;
    logic [1:0]                w_quad;
    logic [W_ANG-1:0]          w_resid;
    logic signed [W_PRE-1:0]   w_x;
    logic signed [W_PRE-1:0]   w_y;
    logic signed [W_PRE-1:0]   w_xq;
    logic signed [W_PRE-1:0]   w_yq;

    // nearest quarter turn and signed residual
    assign w_ang_bias = i_pt.angle + W_ANG'(16'h2000);
    assign w_quad     = w_ang_bias[W_ANG-1 -: 2];
    assign w_resid    = i_pt.angle - {w_quad, {(W_ANG-2){1'b0}}};

    assign w_x = W_PRE'(i_pt.x_in);
    assign w_y = W_PRE'(i_pt.y_in);

    // exact quadrant rotation ahead of the multiply
    always_comb begin
        unique case (w_quad)
            QUAD_0: begin
                w_xq = w_x;
                w_yq = w_y;
            end
            QUAD_90: begin
                w_xq = -w_y;
                w_yq = w_x;
            end
            QUAD_180: begin
                w_xq = -w_x;
                w_yq = -w_y;
            end
            QUAD_270: begin
                w_xq = w_y;
                w_yq = -w_x;
            end
            default: begin
                w_xq = w_x;
                w_yq = w_y;
            end
        endcase
    end

    // gain compensation, residual angle to 32-bit turn units
    always_comb begin
        n_data.x    = W_ACC'(w_xq) * W_ACC'(GAIN_COMP);
        n_data.y    = W_ACC'(w_yq) * W_ACC'(GAIN_COMP);
        n_data.z    = {w_resid, {(W_Z-W_ANG){1'b0}}};
        n_data.last = i_pt.last_in;
    end

    assign i_pt.ready = ~r_valid | i_ready;

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_pt.ready) begin
            r_valid <= i_pt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pt.ready && i_pt.valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> hw/rtl/pr2d_stage.sv
// One CORDIC micro-rotation with its pipeline register.
// Depends on pr2d_pkg.
module pr2d_stage
    import pr2d_pkg::*;
#(
    parameter int STEP_IDX = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_rot i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_rot o_data
);

    logic                    r_valid;
    t_rot                    r_data;
    t_rot                    n_data;
    logic signed [W_ACC-1:0] w_dx;
    logic signed [W_ACC-1:0] w_dy;

    // floor shifts of the cross terms
    assign w_dx = i_data.y >>> STEP_IDX;
    assign w_dy = i_data.x >>> STEP_IDX;

    // rotate towards zero residual angle
    always_comb begin
        n_data.last = i_data.last;
        if (!i_data.z[W_Z-1]) begin
            n_data.x = i_data.x - w_dx;
            n_data.y = i_data.y + w_dy;
            n_data.z = i_data.z - ATAN_TAB[STEP_IDX];
        end else begin
            n_data.x = i_data.x + w_dx;
            n_data.y = i_data.y - w_dy;
            n_data.z = i_data.z + ATAN_TAB[STEP_IDX];
        end
    end

    assign o_ready = ~r_valid | i_ready;

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> hw/rtl/pr2d_trunc.sv
// Output stage: truncation toward zero to integer and the output register.
// Depends on pr2d_pkg and pr2d_out_if.
module pr2d_trunc
    import pr2d_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_rot      i_data,
    pr2d_out_if.source o_pt
);

    localparam logic signed [W_ACC-1:0] TRUNC_BIAS = W_ACC'((64'd1 << FRAC_BITS) - 64'd1);

    logic                    r_valid;
    logic signed [W_RES-1:0] r_x;
    logic signed [W_RES-1:0] r_y;
    logic                    r_last;
    logic signed [W_ACC-1:0] w_xa;
    logic signed [W_ACC-1:0] w_ya;

    // negative values get a bias so the floor shift rounds toward zero
    assign w_xa = i_data.x[W_ACC-1] ? i_data.x + TRUNC_BIAS : i_data.x;
    assign w_ya = i_data.y[W_ACC-1] ? i_data.y + TRUNC_BIAS : i_data.y;

    assign o_ready = ~r_valid | o_pt.ready;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_x    <= w_xa[FRAC_BITS +: W_RES];
            r_y    <= w_ya[FRAC_BITS +: W_RES];
            r_last <= i_data.last;
        end
    end

    assign o_pt.valid    = r_valid;
    assign o_pt.x_out    = r_x;
    assign o_pt.y_out    = r_y;
    assign o_pt.last_out = r_last;

endmodule

>>> hw/rtl/point_rotation_2d.sv
// Pipelined CORDIC point rotator: one point per cycle while the output accepts, no stall bubbles.
// Registers: the scaling stage, one register per micro-rotation (ROTATION_STEPS,
// capped at the table length), and the truncation stage.
// Throughput: one beat per cycle while the output is ready; each stage holds its beat while stalled.
// Reset clears only the stage valid bits; data registers are not reset.
module point_rotation_2d
    import pr2d_pkg::*;
#(
    parameter int ROTATION_STEPS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pr2d_in_if.sink    i_pt,
    pr2d_out_if.source o_pt
);

    localparam int STEPS = (ROTATION_STEPS < TABLE_LEN) ? ROTATION_STEPS : TABLE_LEN;

    logic w_valid [STEPS+1];
    logic w_ready [STEPS+1];
    t_rot w_data  [STEPS+1];

    // scaling and quadrant stage
    pr2d_prescale u_prescale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (i_pt),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_data  (w_data[0])
    );

    // micro-rotation chain
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        pr2d_stage #(
            .STEP_IDX (k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_data  (w_data[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_data  (w_data[k+1])
        );
    end

    // truncation and output register
    pr2d_trunc u_trunc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[STEPS]),
        .o_ready (w_ready[STEPS]),
        .i_data  (w_data[STEPS]),
        .o_pt    (o_pt)
    );

endmodule
